>>> rtl/core/saca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saca_pkg
// Shared types and constants for the strand angle cost accumulator.
// ----------------------------------------------------------------------------
package saca_pkg;

    // Default fixed-point settings.
    localparam int SACA_FRAC_BITS = 16;
    localparam int SACA_SUM_WIDTH = 48;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DIR_X = 2'd0;
    localparam logic [1:0] CFG_DIR_Y = 2'd1;
    localparam logic [1:0] CFG_DIR_Z = 2'd2;

    // Shared multiplier operand selections.
    localparam logic [3:0] MS_DOT_X  = 4'd0;
    localparam logic [3:0] MS_DOT_Y  = 4'd1;
    localparam logic [3:0] MS_DOT_Z  = 4'd2;
    localparam logic [3:0] MS_VSQ_X  = 4'd3;
    localparam logic [3:0] MS_VSQ_Y  = 4'd4;
    localparam logic [3:0] MS_VSQ_Z  = 4'd5;
    localparam logic [3:0] MS_DSQ_X  = 4'd6;
    localparam logic [3:0] MS_DSQ_Y  = 4'd7;
    localparam logic [3:0] MS_DSQ_Z  = 4'd8;
    localparam logic [3:0] MS_DEN    = 4'd9;
    localparam logic [3:0] MS_BASE   = 4'd10;
    localparam logic [3:0] MS_PRE_LO = 4'd11;
    localparam logic [3:0] MS_PRE_HI = 4'd12;

    // Square root operand selection.
    localparam logic SQ_SEL_V = 1'b0;
    localparam logic SQ_SEL_D = 1'b1;

    // Divider operand selection.
    localparam logic DV_SEL_RATIO = 1'b0;
    localparam logic DV_SEL_PRE   = 1'b1;

    // Number of square root iterations for a 34-bit radicand.
    localparam int SQ_STEPS = 17;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       scale;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       acc_en;
        logic [3:0] acc_sel;
        logic       sq_load;
        logic       sq_step;
        logic       sq_store;
        logic       sq_sel;
        logic       dv_load;
        logic       dv_step;
        logic       dv_sel;
        logic       ratio_take;
        logic       pre_take;
        logic       commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scale_done;
        logic points_two;
        logic out_valid;
    } t_sts;

endpackage

>>> rtl/core/saca_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saca_dp
// Datapath: point history, scaling, shared multiplier, square root and
// divider units, saturating accumulator and the output register.
// ----------------------------------------------------------------------------
module saca_dp
    import saca_pkg::*;
#(
    parameter int FRAC_BITS = SACA_FRAC_BITS,
    parameter int SUM_WIDTH = SACA_SUM_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_radius,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [47:0] o_total_cost,
    output logic [15:0] o_segments
);

    localparam int NUM_W = 34 + FRAC_BITS;
    localparam int DEN_W = 34;
    localparam int DOT_W = 36;
    localparam int MW    = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
    localparam int PW    = (3 * FRAC_BITS + 4 > 65) ? 3 * FRAC_BITS + 4 : 65;
    localparam int PRE_W = 2 * FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    // Configuration and strand state.
    logic signed [31:0] r_dir [3];
    logic signed [31:0] r_prev [3];
    logic [31:0]        r_prev_r;
    logic [1:0]         r_points;
    logic [SUM_WIDTH-1:0] r_sum;
    logic [15:0]        r_cnt;

    // Segment working registers.
    logic [32:0]             r_vm [3];
    logic                    r_vs [3];
    logic [31:0]             r_dm [3];
    logic                    r_ds [3];
    logic [32:0]             r_rsum;
    logic signed [DOT_W-1:0] r_dot;
    logic [DEN_W-1:0]        r_nv2;
    logic [DEN_W-1:0]        r_nd2;
    logic [16:0]             r_nv;
    logic [16:0]             r_nd;
    logic [DEN_W-1:0]        r_den;
    logic [FRAC_BITS:0]      r_base;
    logic [FRAC_BITS:0]      r_sq;
    logic [PRE_W-1:0]        r_pre;
    logic                    r_rs0;
    logic [PW-1:0]           r_pp;
    logic signed [2*MW-1:0]  r_prod;

    // Square root and divider registers.
    logic [DEN_W-1:0] r_sq_rem;
    logic [DEN_W-1:0] r_sq_res;
    logic [DEN_W-1:0] r_sq_bit;
    logic [DEN_W:0]   r_dv_rem;
    logic [NUM_W-1:0] r_dv_quo;
    logic [DEN_W-1:0] r_dv_den;

    // Output register.
    logic        r_out_valid;
    logic [47:0] r_out_total;
    logic [15:0] r_out_segs;

    // Signed operand from a sign and a 16-bit magnitude.
    function automatic logic signed [MW-1:0] f_sgn(input logic s, input logic [15:0] m);
        logic signed [MW-1:0] v;
        v = MW'(m);
        return s ? -v : v;
    endfunction

    // Scaling status: any component still at or above 2^16.
    logic v_big, d_big;
    assign v_big = (|r_vm[0][32:16]) | (|r_vm[1][32:16]) | (|r_vm[2][32:16]);
    assign d_big = (|r_dm[0][31:16]) | (|r_dm[1][31:16]) | (|r_dm[2][31:16]);

    assign o_sts.scale_done = !v_big && !d_big;
    assign o_sts.points_two = (r_points == 2'd2);
    assign o_sts.out_valid  = r_out_valid;

    // Shared multiplier operand selection.
    logic signed [MW-1:0] mul_a, mul_b;
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DOT_X: begin
                mul_a = f_sgn(r_vs[0], r_vm[0][15:0]);
                mul_b = f_sgn(r_ds[0], r_dm[0][15:0]);
            end
            MS_DOT_Y: begin
                mul_a = f_sgn(r_vs[1], r_vm[1][15:0]);
                mul_b = f_sgn(r_ds[1], r_dm[1][15:0]);
            end
            MS_DOT_Z: begin
                mul_a = f_sgn(r_vs[2], r_vm[2][15:0]);
                mul_b = f_sgn(r_ds[2], r_dm[2][15:0]);
            end
            MS_VSQ_X: begin
                mul_a = MW'(r_vm[0][15:0]);
                mul_b = MW'(r_vm[0][15:0]);
            end
            MS_VSQ_Y: begin
                mul_a = MW'(r_vm[1][15:0]);
                mul_b = MW'(r_vm[1][15:0]);
            end
            MS_VSQ_Z: begin
                mul_a = MW'(r_vm[2][15:0]);
                mul_b = MW'(r_vm[2][15:0]);
            end
            MS_DSQ_X: begin
                mul_a = MW'(r_dm[0][15:0]);
                mul_b = MW'(r_dm[0][15:0]);
            end
            MS_DSQ_Y: begin
                mul_a = MW'(r_dm[1][15:0]);
                mul_b = MW'(r_dm[1][15:0]);
            end
            MS_DSQ_Z: begin
                mul_a = MW'(r_dm[2][15:0]);
                mul_b = MW'(r_dm[2][15:0]);
            end
            MS_DEN: begin
                mul_a = MW'(r_nv);
                mul_b = MW'(r_nd);
            end
            MS_BASE: begin
                mul_a = MW'(r_base);
                mul_b = MW'(r_base);
            end
            MS_PRE_LO: begin
                mul_a = MW'(r_pre[FRAC_BITS:0]);
                mul_b = MW'(r_sq);
            end
            MS_PRE_HI: begin
                mul_a = MW'(r_pre[PRE_W-1:FRAC_BITS+1]);
                mul_b = MW'(r_sq);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Segment vector and radius sum at the accepting edge.
    logic signed [32:0] v_new [3];
    logic [31:0]        in_pos [3];
    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;
    assign in_pos[2] = i_pos_z;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_new[i] = 33'(signed'(in_pos[i])) - 33'(r_prev[i]);
        end
    end

    // Square root step.
    logic [DEN_W-1:0] sq_t;
    assign sq_t = r_sq_res + r_sq_bit;

    // Divider step.
    logic [DEN_W:0] dv_sh;
    assign dv_sh = {r_dv_rem[DEN_W-1:0], r_dv_quo[NUM_W-1]};

    // Magnitude of the dot product.
    logic [DOT_W-1:0] dot_mag;
    assign dot_mag = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);

    // Final term and saturating sum.
    logic [PW-1:0]   term;
    logic            term_sat;
    logic [PW:0]     sum_ext;
    logic [SUM_WIDTH-1:0] sum_next;
    assign term     = r_pp >> FRAC_BITS;
    assign term_sat = r_rs0 || ((r_pp >> 64) != '0);
    assign sum_ext  = (PW+1)'(r_sum) + (PW+1)'(term);
    assign sum_next = (term_sat || ((sum_ext >> SUM_WIDTH) != '0)) ? SUM_MAX
                                                                   : SUM_WIDTH'(sum_ext);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_dir[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIR_X: r_dir[0] <= i_cfg_data;
                CFG_DIR_Y: r_dir[1] <= i_cfg_data;
                CFG_DIR_Z: r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Strand state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= '0;
            end
            r_prev_r    <= '0;
            r_points    <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept && i_last) begin
                r_out_valid <= 1'b1;
                r_out_total <= 48'(64'(r_sum));
                r_out_segs  <= r_cnt;
                for (int i = 0; i < 3; i++) begin
                    r_prev[i] <= '0;
                end
                r_prev_r <= '0;
                r_points <= '0;
                r_sum    <= '0;
                r_cnt    <= '0;
            end else if (i_cmd.accept) begin
                for (int i = 0; i < 3; i++) begin
                    r_prev[i] <= in_pos[i];
                end
                r_prev_r <= i_radius;
                if (r_points != 2'd2) begin
                    r_points <= r_points + 2'd1;
                end
            end
            if (i_cmd.commit) begin
                r_sum <= sum_next;
                if (r_cnt != 16'hFFFF) begin
                    r_cnt <= r_cnt + 16'd1;
                end
            end
        end
    end

    // Segment arithmetic.
    always_ff @(posedge i_clk) begin
        // Capture the segment vector and direction magnitudes.
        if (i_cmd.accept) begin
            for (int i = 0; i < 3; i++) begin
                r_vs[i] <= v_new[i][32];
                r_vm[i] <= v_new[i][32] ? 33'(-v_new[i]) : 33'(v_new[i]);
                r_ds[i] <= r_dir[i][31];
                r_dm[i] <= r_dir[i][31] ? 32'(-r_dir[i]) : 32'(r_dir[i]);
            end
            r_rsum <= 33'(r_prev_r) + 33'(i_radius);
            r_dot  <= '0;
            r_nv2  <= '0;
            r_nd2  <= '0;
        end

        // Scale both vectors down one bit a cycle until they fit 16 bits.
        if (i_cmd.scale) begin
            for (int i = 0; i < 3; i++) begin
                if (v_big) begin
                    r_vm[i] <= r_vm[i] >> 1;
                end
                if (d_big) begin
                    r_dm[i] <= r_dm[i] >> 1;
                end
            end
        end

        // Shared multiplier, registered.
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end

        // Accumulate or store the registered product.
        if (i_cmd.acc_en) begin
            unique case (i_cmd.acc_sel)
                MS_DOT_X, MS_DOT_Y, MS_DOT_Z: r_dot <= r_dot + DOT_W'(r_prod);
                MS_VSQ_X, MS_VSQ_Y, MS_VSQ_Z: r_nv2 <= r_nv2 + r_prod[DEN_W-1:0];
                MS_DSQ_X, MS_DSQ_Y, MS_DSQ_Z: r_nd2 <= r_nd2 + r_prod[DEN_W-1:0];
                MS_DEN:    r_den <= r_prod[DEN_W-1:0];
                MS_BASE:   r_sq  <= r_prod[2*FRAC_BITS:FRAC_BITS];
                MS_PRE_LO: r_pp  <= PW'(r_prod[PRE_W-1:0]);
                MS_PRE_HI: r_pp  <= r_pp + (PW'(r_prod[PRE_W-1:0]) << (FRAC_BITS + 1));
                default: ;
            endcase
        end

        // Square root, one result bit per iteration.
        if (i_cmd.sq_load) begin
            r_sq_rem <= (i_cmd.sq_sel == SQ_SEL_D) ? r_nd2 : r_nv2;
            r_sq_res <= '0;
            r_sq_bit <= DEN_W'(1) << 32;
        end else if (i_cmd.sq_step) begin
            if (r_sq_rem >= sq_t) begin
                r_sq_rem <= r_sq_rem - sq_t;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_cmd.sq_store) begin
            if (i_cmd.sq_sel == SQ_SEL_D) begin
                r_nd <= r_sq_res[16:0];
            end else begin
                r_nv <= r_sq_res[16:0];
            end
        end

        // Restoring divider, one quotient bit per cycle.
        if (i_cmd.dv_load) begin
            r_dv_rem <= '0;
            if (i_cmd.dv_sel == DV_SEL_PRE) begin
                r_dv_quo <= NUM_W'(1) << (1 + 2 * FRAC_BITS);
                r_dv_den <= DEN_W'(r_rsum);
            end else begin
                r_dv_quo <= {dot_mag[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                r_dv_den <= r_den;
            end
        end else if (i_cmd.dv_step) begin
            if (dv_sh >= {1'b0, r_dv_den}) begin
                r_dv_rem <= dv_sh - {1'b0, r_dv_den};
                r_dv_quo <= {r_dv_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_dv_rem <= dv_sh;
                r_dv_quo <= {r_dv_quo[NUM_W-2:0], 1'b0};
            end
        end

        // Ratio clamped to one, then the base term.
        if (i_cmd.ratio_take) begin
            if (r_den == '0) begin
                r_base <= ONE_FIX;
            end else if (r_dv_quo > NUM_W'(ONE_FIX)) begin
                r_base <= '0;
            end else begin
                r_base <= ONE_FIX - r_dv_quo[FRAC_BITS:0];
            end
        end

        // Radius weight.
        if (i_cmd.pre_take) begin
            r_pre <= r_dv_quo[PRE_W-1:0];
            r_rs0 <= (r_rsum == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_total_cost = r_out_total;
    assign o_segments   = r_out_segs;

endmodule

>>> rtl/core/saca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saca_ctrl
// Controller: sequences the per-segment arithmetic through the datapath.
// ----------------------------------------------------------------------------
module saca_ctrl
    import saca_pkg::*;
#(
    parameter int FRAC_BITS = SACA_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int NUM_W = 34 + FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_MAC   = 4'd2;
    localparam logic [3:0] S_SQV   = 4'd3;
    localparam logic [3:0] S_SQD   = 4'd4;
    localparam logic [3:0] S_DEN   = 4'd5;
    localparam logic [3:0] S_DIVR  = 4'd6;
    localparam logic [3:0] S_BASE  = 4'd7;
    localparam logic [3:0] S_DIVP  = 4'd8;
    localparam logic [3:0] S_PRE   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          in_ready;
    logic          accept;

    // A last point needs the output register; other points do not.
    assign in_ready   = (r_state == S_IDLE) && (!i_sts.out_valid || i_out_ready || !i_in_last);
    assign accept     = in_ready && i_in_valid;
    assign o_in_ready = in_ready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CW'(1);
        o_cmd   = '0;
        o_cmd.accept = accept;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept && !i_in_last && i_sts.points_two) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_cnt = '0;
                if (i_sts.scale_done) begin
                    n_state = S_MAC;
                end else begin
                    o_cmd.scale = 1'b1;
                end
            end
            S_MAC: begin
                o_cmd.mul_en  = (r_cnt < CW'(9));
                o_cmd.mul_sel = 4'(r_cnt);
                o_cmd.acc_en  = (r_cnt != '0);
                o_cmd.acc_sel = 4'(r_cnt - CW'(1));
                if (r_cnt == CW'(9)) begin
                    n_state = S_SQV;
                    n_cnt   = '0;
                end
            end
            S_SQV, S_SQD: begin
                o_cmd.sq_sel   = (r_state == S_SQD) ? SQ_SEL_D : SQ_SEL_V;
                o_cmd.sq_load  = (r_cnt == '0);
                o_cmd.sq_step  = (r_cnt != '0) && (r_cnt <= CW'(SQ_STEPS));
                o_cmd.sq_store = (r_cnt == CW'(SQ_STEPS + 1));
                if (r_cnt == CW'(SQ_STEPS + 1)) begin
                    n_state = (r_state == S_SQD) ? S_DEN : S_SQD;
                    n_cnt   = '0;
                end
            end
            S_DEN, S_BASE: begin
                o_cmd.mul_sel = (r_state == S_DEN) ? MS_DEN : MS_BASE;
                o_cmd.acc_sel = o_cmd.mul_sel;
                o_cmd.mul_en  = (r_cnt == '0);
                o_cmd.acc_en  = (r_cnt != '0);
                if (r_cnt != '0) begin
                    n_state = (r_state == S_DEN) ? S_DIVR : S_DIVP;
                    n_cnt   = '0;
                end
            end
            S_DIVR, S_DIVP: begin
                o_cmd.dv_sel  = (r_state == S_DIVP) ? DV_SEL_PRE : DV_SEL_RATIO;
                o_cmd.dv_load = (r_cnt == '0);
                o_cmd.dv_step = (r_cnt != '0) && (r_cnt <= CW'(NUM_W));
                if (r_cnt == CW'(NUM_W + 1)) begin
                    o_cmd.ratio_take = (r_state == S_DIVR);
                    o_cmd.pre_take   = (r_state == S_DIVP);
                    n_state = (r_state == S_DIVR) ? S_BASE : S_PRE;
                    n_cnt   = '0;
                end
            end
            S_PRE: begin
                o_cmd.mul_en  = (r_cnt != CW'(2));
                o_cmd.mul_sel = (r_cnt == '0) ? MS_PRE_LO : MS_PRE_HI;
                o_cmd.acc_en  = (r_cnt != '0);
                o_cmd.acc_sel = (r_cnt == CW'(1)) ? MS_PRE_LO : MS_PRE_HI;
                if (r_cnt == CW'(2)) begin
                    n_state = S_ACC;
                    n_cnt   = '0;
                end
            end
            S_ACC: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
                n_cnt        = '0;
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/core/strand_angle_cost_accumulator_top.sv
`timescale 1ns / 1ps
// Flow: a point that closes no counted segment is taken while the block is idle; a point that
// closes a counted segment stalls the input while the segment is scaled, multiplied, rooted
// and divided, set mostly by the bit-serial divider run twice.
// A last point waits while an untaken result is held; its result shows in the next cycle.
// No new point is taken until a segment's arithmetic ends. Reset is synchronous, active low,
// and clears the direction registers, the strand state and the output valid.
// ----------------------------------------------------------------------------
// strand_angle_cost_accumulator_top
// Streams strand control points and emits the saturating angle cost sum and
// the segment count on the last point of each strand.
// ----------------------------------------------------------------------------
module strand_angle_cost_accumulator_top
    import saca_pkg::*;
#(
    parameter int FRAC_BITS = SACA_FRAC_BITS,
    parameter int SUM_WIDTH = SACA_SUM_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Point stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // pos_x, pos_y, pos_z, point_radius
    input  logic         s_axis_tlast,  // last_point
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // total_cost[47:0], segments_used[63:48]
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    t_cmd        cmd;
    t_sts        sts;
    logic [47:0] total_cost;
    logic [15:0] segments;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    saca_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and state.
    saca_dp #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_pos_x      (s_axis_tdata[31:0]),
        .i_pos_y      (s_axis_tdata[63:32]),
        .i_pos_z      (s_axis_tdata[95:64]),
        .i_radius     (s_axis_tdata[127:96]),
        .i_last       (s_axis_tlast),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_total_cost (total_cost),
        .o_segments   (segments)
    );

    assign m_axis_tdata = {segments, total_cost};

endmodule

>>> tb/sv/strand_angle_cost_accumulator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strand_angle_cost_accumulator_top_tb
// Streams strands of control points into the accumulator under several strand
// directions. A scoreboard class works out each strand's angle cost and
// segment count and compares them field by field with the result stream.
// Both stream sides idle and stall at random, except in the last phase.
// ----------------------------------------------------------------------------
module strand_angle_cost_accumulator_top_tb;
    import saca_pkg::*;

    localparam int          FB        = SACA_FRAC_BITS;
    localparam int          SW        = SACA_SUM_WIDTH;
    localparam longint      CYCLE_CAP = 1000000;
    localparam longint unsigned COST_MAX = (64'd1 << SW) - 64'd1;

    typedef longint vec3_t[3];

    typedef struct {
        logic [47:0] cost;
        logic [15:0] segs;
    } strand_sum_t;

    // ------------------------------------------------------------------------
    // Angle cost scoreboard: tracks the strand state and queues strand sums.
    // ------------------------------------------------------------------------
    class angle_cost_board;
        logic [31:0]          dir[3];
        logic [31:0]          prev_pos[3];
        logic [31:0]          prev_rad;
        int                   seen;
        longint unsigned      cost_acc;
        int                   seg_cnt;
        strand_sum_t          pending[$];
        int                   errors;

        function void clear_strand();
            prev_pos = '{default: 32'd0};
            prev_rad = 32'd0;
            seen     = 0;
            cost_acc = 0;
            seg_cnt  = 0;
        endfunction

        function new();
            dir    = '{default: 32'd0};
            errors = 0;
            clear_strand();
        endfunction

        function void set_dir(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                CFG_DIR_X: dir[0] = val;
                CFG_DIR_Y: dir[1] = val;
                CFG_DIR_Z: dir[2] = val;
                default: ;
            endcase
        endfunction

        function longint unsigned mag(input longint c);
            return (c < 0) ? longint'(-c) : longint'(c);
        endfunction

        // Shift a vector down until every component fits 16 bits.
        function vec3_t shrink(input vec3_t c);
            vec3_t           o;
            longint unsigned m;
            int              s;
            m = 0;
            s = 0;
            for (int i = 0; i < 3; i++) if (mag(c[i]) > m) m = mag(c[i]);
            while ((m >> s) >= 65536) s++;
            for (int i = 0; i < 3; i++) begin
                o[i] = longint'(mag(c[i]) >> s);
                if (c[i] < 0) o[i] = -o[i];
            end
            return o;
        endfunction

        function longint unsigned root(input longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint unsigned segment_cost(input logic [31:0] q[3],
                                               input logic [31:0] r2);
            vec3_t           v, d, vr, dr;
            longint          dot;
            longint unsigned nv2, nd2, den, ratio, base, sq, rsum, pre;
            for (int i = 0; i < 3; i++) begin
                v[i] = longint'($signed(q[i])) - longint'($signed(prev_pos[i]));
                d[i] = longint'($signed(dir[i]));
            end
            vr  = shrink(v);
            dr  = shrink(d);
            dot = 0;
            nv2 = 0;
            nd2 = 0;
            for (int i = 0; i < 3; i++) begin
                dot += vr[i] * dr[i];
                nv2 += mag(vr[i]) * mag(vr[i]);
                nd2 += mag(dr[i]) * mag(dr[i]);
            end
            den   = root(nv2) * root(nd2);
            ratio = (den == 0) ? 0 : (mag(dot) << FB) / den;
            if (ratio > (64'd1 << FB)) ratio = 64'd1 << FB;
            base = (64'd1 << FB) - ratio;
            sq   = (base * base) >> FB;
            rsum = longint'(prev_rad) + longint'(r2);
            if (rsum == 0) return COST_MAX;
            pre = (64'd1 << (1 + 2 * FB)) / rsum;
            if (sq != 0 && pre > ({64{1'b1}} / sq)) return COST_MAX;
            return (pre * sq) >> FB;
        endfunction

        // Called on every accepted point transaction.
        function void note_point(input logic [31:0] q[3], input logic [31:0] r,
                                 input logic last);
            longint unsigned term;
            strand_sum_t     e;
            if (seen >= 2 && !last) begin
                term = segment_cost(q, r);
                if (term > COST_MAX - cost_acc) cost_acc = COST_MAX;
                else cost_acc += term;
                if (seg_cnt < 65535) seg_cnt++;
            end
            if (last) begin
                e.cost = cost_acc[47:0];
                e.segs = seg_cnt[15:0];
                pending.push_back(e);
                clear_strand();
            end else begin
                prev_pos = q;
                prev_rad = r;
                if (seen < 2) seen++;
            end
        endfunction

        // Called on every accepted result transaction.
        function void check_result(input logic [63:0] data);
            strand_sum_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $realtime, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[47:0] !== e.cost) begin
                $display("%0t: total_cost expected %h actual %h",
                         $realtime, e.cost, data[47:0]);
                errors++;
            end
            if (data[63:48] !== e.segs) begin
                $display("%0t: segments_used expected %0d actual %0d",
                         $realtime, e.segs, data[63:48]);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [63:0]   m_axis_tdata;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [31:0]   i_cfg_data;

    angle_cost_board board;
    bit              quiet;
    longint          cycles;

    strand_angle_cost_accumulator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle cap guarding against a hung block.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("strand_angle_cost_accumulator_top_tb: done, errors");
            $finish;
        end
    end

    // Result side: random stall bursts, checking each accepted transaction.
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Write one direction register and mirror it in the scoreboard.
    task automatic write_dir(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_dir(idx, val);
    endtask

    task automatic set_direction(input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] z);
        write_dir(CFG_DIR_X, x);
        write_dir(CFG_DIR_Y, y);
        write_dir(CFG_DIR_Z, z);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one control point, with an optional idle burst in front.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] r,
                              input logic last);
        logic [31:0] q[3];
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, z, y, x};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        q = '{x, y, z};
        board.note_point(q, r, last);
    endtask

    // Let the block drain before touching the registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [31:0] rand_radius();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(1 << 12, 1 << 18);
        endcase
    endfunction

    // One strand of random content; occasionally repeats a point.
    task automatic random_strand(input int npts);
        logic [31:0] x, y, z;
        for (int k = 0; k < npts; k++) begin
            if (k == 0 || $urandom_range(0, 9) != 0) begin
                x = rand_coord();
                y = rand_coord();
                z = rand_coord();
            end
            send_point(x, y, z, rand_radius(), k == npts - 1);
        end
    endtask

    task automatic random_phase(input int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14)
                                            : $urandom_range(1, 6);
            random_strand(n);
            sent += n;
        end
        drain();
    endtask

    // Directed strands: short strands, zero-length and parallel segments,
    // zero radius sum and extreme coordinates and radii.
    task automatic directed_points();
        send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
        send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
        send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
        send_point(32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
        send_point(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
        send_point(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0);
        send_point(32'h0, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'h1, 1'b1);
        drain();
    endtask

    initial begin
        board         = new();
        quiet         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_DIR_X;
        i_cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero direction from reset, then along x.
        directed_points();
        set_direction(32'h0001_0000, 32'h0, 32'h0);
        directed_points();

        // Random content under several directions, extremes among them.
        set_direction(32'h7fff_ffff, 32'h8000_0000, 32'h0);
        random_phase(80);
        set_direction(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        random_phase(80);
        set_direction($urandom, $urandom, $urandom);
        random_phase(80);
        set_direction(32'h0, 32'h0, 32'hffff_ffff);
        random_phase(80);
        set_direction(32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                      32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                      32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
        quiet = 1'b1;
        random_phase(80);

        if (board.errors == 0) begin
            $display("strand_angle_cost_accumulator_top_tb: done, clean");
        end else begin
            $display("strand_angle_cost_accumulator_top_tb: done, errors");
        end
        $finish;
    end

endmodule
